@@ src/ffc_pkg.sv @@
// shared constants, codes and types of the frustum cull classifier
// no dependencies; used by every module of the block
package ffc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int SLOT_W = 16;
  localparam int PLANE_W = 4 * SLOT_W;
  localparam int CFG_IDX_W = 3;

  localparam int COORD_BITS_DEF = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // slot positions inside one plane register
  localparam int SLOT_NX = 0;
  localparam int SLOT_NY = 1;
  localparam int SLOT_NZ = 2;
  localparam int SLOT_OFS = 3;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_POINT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SPHERE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BOX = 2'd2;

  localparam int VERDICT_W = 2;
  localparam logic [VERDICT_W-1:0] V_OUTSIDE = 2'd0;
  localparam logic [VERDICT_W-1:0] V_INTERSECT = 2'd1;
  localparam logic [VERDICT_W-1:0] V_INSIDE = 2'd2;

  // per-plane result of one test
  typedef struct packed {
    logic outside;
    logic partial;
  } plane_flags_t;

endpackage

@@ src/ffc_plane_eval.sv @@
// one frustum plane: product stage and signed distance compare
// depends on ffc_pkg
module ffc_plane_eval #(
  parameter int COORD_BITS = ffc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = ffc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [ffc_pkg::PLANE_W-1:0]     plane,
  input  logic [ffc_pkg::ACT_W-1:0]       act_a,
  input  logic [2:0][COORD_BITS-1:0]      lo_a,
  input  logic [2:0][COORD_BITS-1:0]      hi_a,
  input  logic [ffc_pkg::ACT_W-1:0]       act_b,
  input  logic [COORD_BITS-2:0]           radius_b,
  output ffc_pkg::plane_flags_t           flags
);
  import ffc_pkg::*;

  localparam int PW = SLOT_W + COORD_BITS;
  localparam int OW = SLOT_W + NORMAL_FRAC_BITS;
  localparam int RW = COORD_BITS + NORMAL_FRAC_BITS;
  localparam int MW = (PW > OW) ? ((PW > RW) ? PW : RW) : ((OW > RW) ? OW : RW);
  localparam int DW = MW + 3;

  logic signed [PW-1:0] pos_term [3];
  logic signed [PW-1:0] neg_term [3];

  // box: products against both corners, sorted into positive and negative vertex; else the first corner only
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [SLOT_W-1:0] n;
    logic signed [PW-1:0] t_lo;
    logic signed [PW-1:0] t_hi;
    logic box;

    assign n = plane[k*SLOT_W +: SLOT_W];
    assign t_lo = n * $signed(lo_a[k]);
    assign t_hi = n * $signed(hi_a[k]);
    assign box = (act_a == ACT_BOX);

    always_ff @(posedge clk) begin
      if (load) begin
        if (box && !n[SLOT_W-1]) begin
          pos_term[k] <= t_hi;
          neg_term[k] <= t_lo;
        end else if (box) begin
          pos_term[k] <= t_lo;
          neg_term[k] <= t_hi;
        end else begin
          pos_term[k] <= t_lo;
          neg_term[k] <= t_lo;
        end
      end
    end
  end

  logic signed [OW-1:0] ofs_s;
  logic signed [DW-1:0] d_pos;
  logic signed [DW-1:0] d_neg;
  logic signed [DW-1:0] rad_s;

  assign ofs_s = {plane[SLOT_OFS*SLOT_W +: SLOT_W], {NORMAL_FRAC_BITS{1'b0}}};
  assign d_pos = DW'(pos_term[0]) + DW'(pos_term[1]) + DW'(pos_term[2]) + DW'(ofs_s);
  assign d_neg = DW'(neg_term[0]) + DW'(neg_term[1]) + DW'(neg_term[2]) + DW'(ofs_s);
  assign rad_s = DW'({1'b0, radius_b, {NORMAL_FRAC_BITS{1'b0}}});

  always_comb begin
    flags = '0;
    case (act_b)
      ACT_POINT: begin
        flags.outside = d_pos[DW-1];
      end
      ACT_SPHERE: begin
        flags.outside = (d_pos < -rad_s);
        flags.partial = (d_pos < rad_s);
      end
      ACT_BOX: begin
        flags.outside = d_pos[DW-1];
        flags.partial = d_neg[DW-1];
      end
      default: begin
        flags.outside = 1'b1;
      end
    endcase
  end

endmodule

@@ src/frustum_cull_classifier_top.sv @@
// top level of the six-plane frustum cull classifier
// depends on ffc_pkg and ffc_plane_eval
//
// Classifies a point, a sphere or an axis-aligned box against six planes
// loaded through the write port (index 0..5: top, bottom, left, right, near,
// far; each packs nx, ny, nz in bits 15:0, 31:16, 47:32 as signed fixed point
// with NORMAL_FRAC_BITS fraction bits and a signed integer offset in 63:48).
// Distances are exact, no rounding. One item is taken every clock cycle
// while in_ready is high; the item is captured in the input register at
// the accepting edge, moves on to the product register and then to the
// verdict register, which raises out_valid. Thirty-six signed multipliers,
// three for each corner of each plane, work in parallel in the product
// stage. Each stage moves on whenever the one after it is free or draining,
// so items keep entering while a verdict waits on out_ready until the input
// and product registers both hold one. Planes are to be written only while
// the block holds no item; writes to index 6 or 7 are dropped.
module frustum_cull_classifier_top #(
  parameter int COORD_BITS = ffc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = ffc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // plane write port
  input  logic                              cfg_we,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffc_pkg::PLANE_W-1:0]       cfg_data,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ffc_pkg::ACT_W-1:0]         action,
  input  logic signed [COORD_BITS-1:0]      pos_x,
  input  logic signed [COORD_BITS-1:0]      pos_y,
  input  logic signed [COORD_BITS-1:0]      pos_z,
  input  logic [COORD_BITS-2:0]             radius,
  input  logic signed [COORD_BITS-1:0]      box_max_x,
  input  logic signed [COORD_BITS-1:0]      box_max_y,
  input  logic signed [COORD_BITS-1:0]      box_max_z,
  // result item channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffc_pkg::VERDICT_W-1:0]     verdict
);
  import ffc_pkg::*;

  // plane registers, all cleared by reset
  logic [PLANE_W-1:0] plane [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
      plane[cfg_index] <= cfg_data;
    end
  end

  // stage enables: a stage loads when the next one is empty or moving
  logic en_out;
  logic en_b;
  logic en_a;
  logic v_a;
  logic v_b;

  assign en_out = !out_valid || out_ready;
  assign en_b = !v_b || en_out;
  assign en_a = !v_a || en_b;
  assign in_ready = en_a;

  // input register
  logic [ACT_W-1:0] act_a;
  logic [2:0][COORD_BITS-1:0] lo_a;
  logic [2:0][COORD_BITS-1:0] hi_a;
  logic [COORD_BITS-2:0] rad_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en_a) begin
      v_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      act_a <= action;
      lo_a <= {pos_z, pos_y, pos_x};
      hi_a <= {box_max_z, box_max_y, box_max_x};
      rad_a <= radius;
    end
  end

  // product stage control; the products themselves sit in each plane unit
  logic [ACT_W-1:0] act_b;
  logic [COORD_BITS-2:0] rad_b;
  logic load_b;

  assign load_b = en_b && v_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en_b) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      act_b <= act_a;
      rad_b <= rad_a;
    end
  end

  // six plane units in parallel
  plane_flags_t flags [NUM_PLANES];

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
    ffc_plane_eval #(
      .COORD_BITS      (COORD_BITS),
      .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_plane (
      .clk     (clk),
      .load    (load_b),
      .plane   (plane[i]),
      .act_a   (act_a),
      .lo_a    (lo_a),
      .hi_a    (hi_a),
      .act_b   (act_b),
      .radius_b(rad_b),
      .flags   (flags[i])
    );
  end

  // outside on any plane wins, then a cut through any plane
  logic any_outside;
  logic any_partial;
  logic [VERDICT_W-1:0] verdict_next;

  always_comb begin
    any_outside = 1'b0;
    any_partial = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      any_outside = any_outside | flags[i].outside;
      any_partial = any_partial | flags[i].partial;
    end
    if (any_outside) begin
      verdict_next = V_OUTSIDE;
    end else if (any_partial) begin
      verdict_next = V_INTERSECT;
    end else begin
      verdict_next = V_INSIDE;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v_b) begin
      verdict <= verdict_next;
    end
  end

endmodule

@@ src/ffc_checker.sv @@
// port-level checks of the frustum cull classifier, bound to its top level
// depends on ffc_pkg and frustum_cull_classifier_top
module ffc_checker #(
  parameter int COORD_BITS = ffc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = ffc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffc_pkg::PLANE_W-1:0]       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ffc_pkg::ACT_W-1:0]         action,
  input  logic signed [COORD_BITS-1:0]      pos_x,
  input  logic signed [COORD_BITS-1:0]      pos_y,
  input  logic signed [COORD_BITS-1:0]      pos_z,
  input  logic [COORD_BITS-2:0]             radius,
  input  logic signed [COORD_BITS-1:0]      box_max_x,
  input  logic signed [COORD_BITS-1:0]      box_max_y,
  input  logic signed [COORD_BITS-1:0]      box_max_z,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ffc_pkg::VERDICT_W-1:0]     verdict
);

  // a waiting verdict stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a draining output never blocks the input side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output drains");

  // with the output side open, an accepted item reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item did not reach the output in time");

endmodule

bind frustum_cull_classifier_top ffc_checker #(
  .COORD_BITS      (COORD_BITS),
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_ffc_checker (.*);

@@ tb/cull_verdict_checker.sv @@
`timescale 1ns / 1ps
// verdict checker for the frustum cull classifier: mirrors plane writes,
// predicts one verdict per accepted item and compares it on the result channel
// depends on ffc_pkg only
module cull_verdict_checker #(
  parameter int COORD_BITS = ffc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = ffc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffc_pkg::PLANE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ffc_pkg::ACT_W-1:0]     action,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  input  logic [COORD_BITS-2:0]         radius,
  input  logic signed [COORD_BITS-1:0]  box_max_x,
  input  logic signed [COORD_BITS-1:0]  box_max_y,
  input  logic signed [COORD_BITS-1:0]  box_max_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ffc_pkg::VERDICT_W-1:0] verdict,
  output int                            fail_count,
  output int                            pending,
  output int                            n_outside,
  output int                            n_intersect,
  output int                            n_inside
);
  import ffc_pkg::*;

  typedef struct {
    logic [VERDICT_W-1:0] verdict;
    int                   seq;
  } expected_verdict_t;

  logic [PLANE_W-1:0] plane_copy [NUM_PLANES];
  expected_verdict_t  expected_verdicts [$];
  int                 n_accepted;

  // exact signed distance in units of 2^-NORMAL_FRAC_BITS
  function automatic longint plane_distance(input logic [PLANE_W-1:0] pl,
                                            input longint x, input longint y,
                                            input longint z);
    longint nx, ny, nz, ofs;
    nx = $signed(pl[SLOT_NX*SLOT_W +: SLOT_W]);
    ny = $signed(pl[SLOT_NY*SLOT_W +: SLOT_W]);
    nz = $signed(pl[SLOT_NZ*SLOT_W +: SLOT_W]);
    ofs = $signed(pl[SLOT_OFS*SLOT_W +: SLOT_W]);
    return nx * x + ny * y + nz * z + ofs * (longint'(1) << NORMAL_FRAC_BITS);
  endfunction

  function automatic logic [VERDICT_W-1:0] classify_item(
      input logic [ACT_W-1:0] act,
      input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] py,
      input logic signed [COORD_BITS-1:0] pz, input logic [COORD_BITS-2:0] rad_in,
      input logic signed [COORD_BITS-1:0] qx, input logic signed [COORD_BITS-1:0] qy,
      input logic signed [COORD_BITS-1:0] qz);
    logic [VERDICT_W-1:0] v;
    logic [PLANE_W-1:0]   pl;
    longint               rad, d;
    bit                   ux, uy, uz;
    v = V_INSIDE;
    rad = longint'(rad_in) * (longint'(1) << NORMAL_FRAC_BITS);
    if (act != ACT_POINT && act != ACT_SPHERE && act != ACT_BOX)
      return V_OUTSIDE;
    for (int i = 0; i < NUM_PLANES; i++) begin
      pl = plane_copy[i];
      case (act)
        ACT_POINT: begin
          if (plane_distance(pl, px, py, pz) < 0)
            return V_OUTSIDE;
        end
        ACT_SPHERE: begin
          d = plane_distance(pl, px, py, pz);
          if (d < -rad)
            return V_OUTSIDE;
          if (d < rad)
            v = V_INTERSECT;
        end
        default: begin
          // corner pick per axis by normal sign, no swap of inverted boxes
          ux = !pl[SLOT_NX*SLOT_W + SLOT_W - 1];
          uy = !pl[SLOT_NY*SLOT_W + SLOT_W - 1];
          uz = !pl[SLOT_NZ*SLOT_W + SLOT_W - 1];
          if (plane_distance(pl, ux ? qx : px, uy ? qy : py, uz ? qz : pz) < 0)
            return V_OUTSIDE;
          if (plane_distance(pl, ux ? px : qx, uy ? py : qy, uz ? pz : qz) < 0)
            v = V_INTERSECT;
        end
      endcase
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    expected_verdict_t e;
    if (rst) begin
      foreach (plane_copy[i])
        plane_copy[i] = '0;
      expected_verdicts.delete();
      n_accepted = 0;
      fail_count = 0;
      pending = 0;
      n_outside = 0;
      n_intersect = 0;
      n_inside = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t checker: verdict %0d arrived with no item outstanding",
                   $time, verdict);
          fail_count++;
        end else begin
          e = expected_verdicts.pop_front();
          if (verdict !== e.verdict) begin
            $display("%0t checker: item %0d verdict expected %0d actual %0d",
                     $time, e.seq, e.verdict, verdict);
            fail_count++;
          end
          case (e.verdict)
            V_OUTSIDE:   n_outside++;
            V_INTERSECT: n_intersect++;
            default:     n_inside++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        e.verdict = classify_item(action, pos_x, pos_y, pos_z, radius,
                                  box_max_x, box_max_y, box_max_z);
        e.seq = n_accepted;
        n_accepted++;
        expected_verdicts.push_back(e);
      end
      // writes land after this edge's prediction, unlike the block, which reads the planes in its later stages
      if (cfg_we && cfg_index < NUM_PLANES)
        plane_copy[cfg_index] = cfg_data;
      pending = expected_verdicts.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench top for the frustum cull classifier: clock, reset, plane loads,
// item stimulus with random idling and a long output stall, watchdog, verdict
// depends on ffc_pkg, frustum_cull_classifier_top and cull_verdict_checker
module tb;
  import ffc_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  // action code the block treats as unused; answered with outside
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES = 400;    // long output stall, fills the pipeline
  localparam int DRAIN_CYCLES = 8;     // settle time after the last verdict
  localparam logic signed [SLOT_W-1:0] NORM_ONE = SLOT_W'(1 << NORMAL_FRAC_BITS_DEF);
  localparam logic signed [SLOT_W-1:0] NORM_NEG_ONE = -NORM_ONE;

  typedef enum logic [CFG_IDX_W-1:0] {
    PL_TOP, PL_BOTTOM, PL_LEFT, PL_RIGHT, PL_NEAR, PL_FAR, PL_SPARE6, PL_SPARE7
  } plane_idx_e;

  typedef struct {
    logic [ACT_W-1:0]     act;
    logic signed [CW-1:0] px, py, pz;
    logic [CW-2:0]        rad;
    logic signed [CW-1:0] qx, qy, qz;
  } cull_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [PLANE_W-1:0]    cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACT_W-1:0]      action = '0;
  logic signed [CW-1:0]  pos_x = '0;
  logic signed [CW-1:0]  pos_y = '0;
  logic signed [CW-1:0]  pos_z = '0;
  logic [CW-2:0]         radius = '0;
  logic signed [CW-1:0]  box_max_x = '0;
  logic signed [CW-1:0]  box_max_y = '0;
  logic signed [CW-1:0]  box_max_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VERDICT_W-1:0]  verdict;

  int fail_count, pending, n_outside, n_intersect, n_inside;

  // shared between the item source and the result sink
  bit busy = 1'b0;       // random idling on both sides
  bit hold_req = 1'b0;   // ask the sink for one long stall

  logic [PLANE_W-1:0] next_planes [NUM_PLANES];
  logic [ACT_W-1:0]   test_kinds [3] = '{ACT_POINT, ACT_SPHERE, ACT_BOX};
  int                 act_count [4] = '{0, 0, 0, 0};
  int                 sets_loaded = 0;

  frustum_cull_classifier_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .radius    (radius),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

  cull_verdict_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .radius      (radius),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y),
    .box_max_z   (box_max_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_outside   (n_outside),
    .n_intersect (n_intersect),
    .n_inside    (n_inside)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // register layout: offset on top, then nz, ny, nx
  function automatic logic [PLANE_W-1:0] pack_plane(input logic signed [SLOT_W-1:0] nx,
                                                    input logic signed [SLOT_W-1:0] ny,
                                                    input logic signed [SLOT_W-1:0] nz,
                                                    input logic signed [SLOT_W-1:0] ofs);
    return {ofs, nz, ny, nx};
  endfunction

  function automatic cull_item_t make_item(input logic [ACT_W-1:0] act,
                                           input int px, input int py, input int pz,
                                           input int rd,
                                           input int qx, input int qy, input int qz);
    cull_item_t it;
    it.act = act;
    it.px = px[CW-1:0];
    it.py = py[CW-1:0];
    it.pz = pz[CW-1:0];
    it.rad = rd[CW-2:0];
    it.qx = qx[CW-1:0];
    it.qy = qy[CW-1:0];
    it.qz = qz[CW-1:0];
    return it;
  endfunction

  // near the frustum most of the time, anywhere in the field range otherwise
  function automatic logic signed [CW-1:0] rand_coord(input bit wide);
    int v;
    if (wide)
      v = $urandom();
    else
      v = $urandom_range(0, 4000) - 2000;
    return v[CW-1:0];
  endfunction

  function automatic cull_item_t random_item(input bit wide_ok);
    cull_item_t it;
    logic signed [CW-1:0] t;
    bit wide;
    wide = wide_ok && $urandom_range(0, 3) == 0;
    it.act = ($urandom_range(0, 19) == 0) ? ACT_RESERVED : test_kinds[$urandom_range(0, 2)];
    it.px = rand_coord(wide);
    it.py = rand_coord(wide);
    it.pz = rand_coord(wide);
    it.rad = (CW-1)'(wide ? $urandom_range(0, 32767) : $urandom_range(0, 1500));
    if (wide) begin
      it.qx = rand_coord(1'b1);
      it.qy = rand_coord(1'b1);
      it.qz = rand_coord(1'b1);
    end else begin
      it.qx = CW'(it.px + $urandom_range(0, 1500));
      it.qy = CW'(it.py + $urandom_range(0, 1500));
      it.qz = CW'(it.pz + $urandom_range(0, 1500));
      // now and then an inverted box on one axis
      if ($urandom_range(0, 9) == 0) begin
        t = it.qy;
        it.qy = it.py;
        it.py = t;
      end
    end
    return it;
  endfunction

  // tilted planes with normals within +-1.0 and offsets near the origin, or raw random words
  function automatic logic [PLANE_W-1:0] random_plane(input bit raw);
    if (raw)
      return {$urandom(), $urandom()};
    return pack_plane(SLOT_W'($urandom_range(0, 32768) - 16384),
                      SLOT_W'($urandom_range(0, 32768) - 16384),
                      SLOT_W'($urandom_range(0, 32768) - 16384),
                      SLOT_W'($urandom_range(0, 4000) - 2000));
  endfunction

  // axis-aligned cube of half size 1000 around the origin, normals pointing in
  task automatic set_cube_planes();
    next_planes[PL_TOP]    = pack_plane(0, NORM_NEG_ONE, 0, 1000);
    next_planes[PL_BOTTOM] = pack_plane(0, NORM_ONE, 0, 1000);
    next_planes[PL_LEFT]   = pack_plane(NORM_ONE, 0, 0, 1000);
    next_planes[PL_RIGHT]  = pack_plane(NORM_NEG_ONE, 0, 0, 1000);
    next_planes[PL_NEAR]   = pack_plane(0, 0, NORM_ONE, 1000);
    next_planes[PL_FAR]    = pack_plane(0, 0, NORM_NEG_ONE, 1000);
  endtask

  // planes change only with the block empty: drop valid, wait for every
  // verdict, let the pipeline settle, then write all six back to back
  task automatic load_planes(input bit spare);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < NUM_PLANES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= plane_idx_e'(i);
      cfg_data <= next_planes[i];
      @(negedge clk);
    end
    // the two unused indexes must be dropped by the block
    if (spare) begin
      cfg_index <= PL_SPARE6;
      cfg_data <= {$urandom(), $urandom()};
      @(negedge clk);
      cfg_index <= PL_SPARE7;
      cfg_data <= {$urandom(), $urandom()};
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    sets_loaded++;
  endtask

  // offer one item, optionally after a short gap, and wait for the handshake
  task automatic send_item(input cull_item_t it);
    int gap;
    gap = (busy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action <= it.act;
    pos_x <= it.px;
    pos_y <= it.py;
    pos_z <= it.pz;
    radius <= it.rad;
    box_max_x <= it.qx;
    box_max_y <= it.qy;
    box_max_z <= it.qz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    act_count[it.act]++;
  endtask

  // idling comes and goes in stretches of 64 items; calm keeps it off
  task automatic run_random(input int n, input bit calm, input int hold_at);
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0)
        busy = !calm && $urandom_range(0, 2) != 0;
      if (k == hold_at)
        hold_req = 1'b1;
      send_item(random_item(1'b1));
    end
  endtask

  // result sink: random short stalls, plus one long stall on request
  initial begin : result_sink
    int n;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (busy && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any handshake or write ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles, %0d verdicts outstanding",
             QUIET_LIMIT, pending);
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // planes at reset are all zero: every distance is zero
    send_item(make_item(ACT_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_SPHERE, 5, -5, 5, 0, 0, 0, 0));
    send_item(make_item(ACT_SPHERE, -32768, 32767, 0, 32767, 0, 0, 0));
    send_item(make_item(ACT_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767));

    set_cube_planes();
    load_planes(1'b0);
    // points: center, on the faces, just past a face, the far corners
    send_item(make_item(ACT_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_POINT, 1000, -1000, 1000, 0, 0, 0, 0));
    send_item(make_item(ACT_POINT, 1001, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
    send_item(make_item(ACT_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    // point with radius and box fields full of junk, which it ignores
    send_item(make_item(ACT_POINT, 10, 20, 30, 32767, -32768, 32767, -32768));
    // spheres: touching from outside, just clear, exactly filling, huge
    send_item(make_item(ACT_SPHERE, 1100, 0, 0, 100, 0, 0, 0));
    send_item(make_item(ACT_SPHERE, 1101, 0, 0, 100, 0, 0, 0));
    send_item(make_item(ACT_SPHERE, 0, 0, 0, 1000, 0, 0, 0));
    send_item(make_item(ACT_SPHERE, -32768, -32768, -32768, 32767, 32767, -32768, 32767));
    send_item(make_item(ACT_SPHERE, 0, 0, 0, 0, -32768, -32768, -32768));
    // boxes: inside, straddling a face, fully out, inverted, whole field
    send_item(make_item(ACT_BOX, -10, -10, -10, 0, 10, 10, 10));
    send_item(make_item(ACT_BOX, 900, -10, -10, 32767, 1100, 10, 10));
    send_item(make_item(ACT_BOX, 1001, 0, 0, 0, 2000, 5, 5));
    send_item(make_item(ACT_BOX, 10, 10, 10, 0, -10, -10, -10));
    send_item(make_item(ACT_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767));
    // unused action on a point that would be inside, then on junk fields
    send_item(make_item(ACT_RESERVED, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_RESERVED, -32768, 32767, -1, 32767, 32767, -32768, 1));

    // cube frustum with idling and one long output stall
    run_random(400, 1'b0, 150);

    // tilted planes
    foreach (next_planes[i])
      next_planes[i] = random_plane(1'b0);
    load_planes(1'b0);
    run_random(400, 1'b0, -1);

    // extreme register contents: most negative, most positive, all ones
    foreach (next_planes[i])
      next_planes[i] = {(PLANE_W / SLOT_W){16'h8000}};
    load_planes(1'b0);
    run_random(60, 1'b0, -1);
    foreach (next_planes[i])
      next_planes[i] = {(PLANE_W / SLOT_W){16'h7fff}};
    load_planes(1'b0);
    run_random(60, 1'b0, -1);
    foreach (next_planes[i])
      next_planes[i] = '1;
    load_planes(1'b0);
    run_random(60, 1'b0, -1);

    // raw random words, plus writes to the unused indexes
    foreach (next_planes[i])
      next_planes[i] = random_plane(1'b1);
    load_planes(1'b1);
    run_random(300, 1'b0, -1);

    // closing stretch at full rate with no idling on either side
    set_cube_planes();
    load_planes(1'b0);
    run_random(500, 1'b1, -1);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d point, %0d sphere, %0d box, %0d unused-action items over %0d plane loads",
             act_count[ACT_POINT], act_count[ACT_SPHERE], act_count[ACT_BOX],
             act_count[ACT_RESERVED], sets_loaded);
    $display("summary: verdicts %0d outside, %0d intersecting, %0d inside, %0d mismatches",
             n_outside, n_intersect, n_inside, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
